### hdl/swa_pkg.sv
// swa_pkg: shared constants, types and sequencer states for the sliding window average
// used by swa_ring, swa_div and sliding_window_average; no dependencies
package swa_pkg;

	// sizing of the window store and the sample path
	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int LEN_W       = 7;
	localparam int PTR_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W       = SAMPLE_BITS + PTR_W;
	localparam int STEP_W      = $clog2(SUM_W + 1);
	localparam int CMP_W       = (LEN_W > CNT_W) ? LEN_W : CNT_W;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV
	} swa_state_t;

	// ring store access
	typedef struct packed {
		logic                          wr_en;
		logic [PTR_W-1:0]              wr_addr;
		logic signed [SAMPLE_BITS-1:0] wr_data;
		logic                          rd_en;
		logic [PTR_W-1:0]              rd_addr;
	} ring_req_t;

	// divider request and response
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hdl/sliding_window_average.sv
// sliding_window_average: boxcar moving average over a stream of signed samples
// Input channel in_valid/in_ready carries sample and last_sample; the output channel
// out_valid/out_ready carries average, the window sum divided by the window length,
// truncated toward zero. A window length is written with cfg_wr_en/window_len while
// idle; 0 acts as 1, values above 64 act as 64, and every write restarts the window.
// Each transaction reads the oldest sample from the ring store, updates the running sum
// and fill count and, once the window is full, runs the divider, one quotient bit per
// cycle over the 22-bit sum. A new sample is accepted only when the sequencer is back
// in idle, so a transaction that gives a result holds the block until the divider
// finishes, and the divider sets the rate.
// A sample with last_sample set is averaged as usual and then restarts the window.
// The result sits in an output register, so the next transaction is accepted while it
// waits; if the receiver stalls, the following result waits in the divider.
// Reset empties the window, clears out_valid and sets the window length to 4.
// Depends on swa_pkg, swa_ring and swa_div.
module sliding_window_average (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   last_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [swa_pkg::SAMPLE_BITS-1:0] average,
	input  logic                                   cfg_wr_en,
	input  logic [swa_pkg::LEN_W-1:0]              window_len
);
	import swa_pkg::*;

	swa_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic [LEN_W-1:0]              win_len_q;
	logic [PTR_W-1:0]              wp_q;
	logic [CNT_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;

	logic [CNT_W-1:0]              eff_len;
	logic [PTR_W-1:0]              wp_eff;
	logic [PTR_W-1:0]              wp_next;
	logic [CNT_W-1:0]              wp_inc;
	logic                          full_before;
	logic [CNT_W-1:0]              fill_next;
	logic                          produce;
	logic signed [SAMPLE_BITS-1:0] old_sample;
	logic signed [SUM_W-1:0]       old_ext;
	logic signed [SUM_W-1:0]       new_ext;
	logic signed [SUM_W-1:0]       sum_next;
	logic                          accept;
	logic                          out_free;
	logic                          load_out;

	ring_req_t ring_req;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	swa_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (old_sample)
	);

	swa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		priority if (win_len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (CMP_W'(win_len_q) > CMP_W'(MAX_WINDOW)) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(win_len_q);
		end
	end

	// ring pointer and fill bookkeeping
	assign wp_eff      = (CNT_W'(wp_q) >= eff_len) ? '0 : wp_q;
	assign wp_inc      = CNT_W'(wp_eff) + 1'b1;
	assign wp_next     = (wp_inc >= eff_len) ? '0 : PTR_W'(wp_inc);
	assign full_before = fill_q >= eff_len;
	assign fill_next   = full_before ? fill_q : fill_q + 1'b1;
	assign produce     = fill_next >= eff_len;

	// running sum update: drop the oldest sample once full, add the new one
	assign old_ext  = full_before ?
		{{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample} : '0;
	assign new_ext  = {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
	assign sum_next = sum_q - old_ext + new_ext;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == ST_DIV) && div_rsp.done && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = produce ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready         = 1'b0;
		ring_req.rd_en   = 1'b0;
		ring_req.rd_addr = wp_eff;
		ring_req.wr_en   = 1'b0;
		ring_req.wr_addr = wp_eff;
		ring_req.wr_data = sample_q;
		div_req.start    = 1'b0;
		div_req.dividend = sum_next;
		div_req.divisor  = eff_len;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				ring_req.rd_en = in_valid;
			end
			ST_UPDATE: begin
				ring_req.wr_en = 1'b1;
				div_req.start  = produce;
			end
			ST_DIV: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_len_q   <= LEN_W'(4);
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				win_len_q <= window_len;
				wp_q      <= '0;
				fill_q    <= '0;
				sum_q     <= '0;
			end else if (state_q == ST_UPDATE) begin
				if (last_q) begin
					wp_q   <= '0;
					fill_q <= '0;
					sum_q  <= '0;
				end else begin
					wp_q   <= wp_next;
					fill_q <= fill_next;
					sum_q  <= sum_next;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			last_q   <= last_sample;
		end
		if (load_out) begin
			average_q <= SAMPLE_BITS'(div_rsp.quotient);
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

`ifndef SYNTHESIS
	// an accepted transaction always goes to the sum update next
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UPDATE)
		else $error("accepted transaction did not reach the update step");

	// fill count never passes the window length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= eff_len)
		else $error("fill count above window length");

	// write pointer stays inside the window
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(wp_q) < eff_len)
		else $error("write pointer outside window");

	// while waiting for a quotient the divider is stepping
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !div_rsp.done) |-> div_rsp.busy)
		else $error("waiting on an idle divider");

	// a result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");
`endif

endmodule

### hdl/swa_ring.sv
// swa_ring: ring store holding the samples of the current window
// one write port, one registered read port; depends on swa_pkg
module swa_ring (
	input  logic                               clk,
	input  swa_pkg::ring_req_t                 req,
	output logic signed [swa_pkg::SAMPLE_BITS-1:0] rd_data
);
	import swa_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/swa_div.sv
// swa_div: restoring divider, one quotient bit per cycle, truncates toward zero
// signed dividend of SUM_W bits over an unsigned divisor; depends on swa_pkg
module swa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  swa_pkg::div_req_t req,
	output swa_pkg::div_rsp_t rsp
);
	import swa_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic              neg_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;

	logic [CNT_W:0]    trial;
	logic              fits;
	logic [SUM_W-1:0]  mag;

	// magnitude of the dividend at start
	assign mag = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);

	// one restoring step
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// control: step counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= STEP_W'(SUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = cnt_q != '0;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

`ifndef SYNTHESIS
	// a finished division leaves the unit idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0)
		else $error("divider done while still stepping");
`endif

endmodule
